[hdl/sawtc_pkg.sv]
// Shared constants, controller states and the command and status bundles of the cache.
package sawtc_pkg;

    localparam int ADDR_BITS_DEF = 20;
    localparam int NUM_WAYS      = 8;
    localparam int NUM_SETS      = 128;
    localparam int LINE_BYTES    = 64;
    localparam int TOTAL_LINES   = NUM_WAYS * NUM_SETS;
    localparam int OFF_BITS      = $clog2(LINE_BYTES);
    localparam int SET_BITS      = $clog2(NUM_SETS);
    localparam int WAY_BITS      = $clog2(NUM_WAYS);
    localparam int SLOT_BITS     = $clog2(TOTAL_LINES);
    localparam int TAG_LO        = OFF_BITS + SET_BITS;
    localparam int LINE_IDX_BITS = SLOT_BITS + OFF_BITS;
    localparam int MAX_LEN       = 4;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic        MODE_WRITE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_CMP,
        ST_RD,
        ST_RCAP,
        ST_WR,
        ST_VICT,
        ST_FRD,
        ST_FWR,
        ST_NEXT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic cmp;
        logic rd_cap;
        logic wr;
        logic vict;
        logic fill_rd;
        logic fill_wr;
        logic next_part;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic hit_now;
        logic last_way;
        logic last_byte;
        logic is_write;
        logic need_fill;
        logic cross_pending;
        logic fill_last;
    } t_stat;

endpackage

[hdl/sawtc_ctrl.sv]
// Controller state machine sequencing clear, lookup, byte transfer and line fill.
module sawtc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output sawtc_pkg::t_cmd  o_cmd,
    input  sawtc_pkg::t_stat i_stat
);

    sawtc_pkg::t_state r_state;
    sawtc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sawtc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sawtc_pkg::ST_CLEAR: begin
                if (i_stat.clr_last) n_state = sawtc_pkg::ST_IDLE;
            end
            sawtc_pkg::ST_IDLE: begin
                if (start) n_state = sawtc_pkg::ST_LOOK;
            end
            sawtc_pkg::ST_LOOK: n_state = sawtc_pkg::ST_CMP;
            sawtc_pkg::ST_CMP: begin
                if (i_stat.hit_now || i_stat.last_way) begin
                    n_state = i_stat.is_write ? sawtc_pkg::ST_WR : sawtc_pkg::ST_RD;
                end else begin
                    n_state = sawtc_pkg::ST_LOOK;
                end
            end
            sawtc_pkg::ST_RD: n_state = sawtc_pkg::ST_RCAP;
            sawtc_pkg::ST_RCAP: begin
                if (!i_stat.last_byte) begin
                    n_state = sawtc_pkg::ST_RD;
                end else if (i_stat.need_fill) begin
                    n_state = sawtc_pkg::ST_VICT;
                end else begin
                    n_state = sawtc_pkg::ST_NEXT;
                end
            end
            sawtc_pkg::ST_WR: begin
                if (i_stat.last_byte) n_state = sawtc_pkg::ST_NEXT;
            end
            sawtc_pkg::ST_VICT: n_state = sawtc_pkg::ST_FRD;
            sawtc_pkg::ST_FRD:  n_state = sawtc_pkg::ST_FWR;
            sawtc_pkg::ST_FWR: begin
                n_state = i_stat.fill_last ? sawtc_pkg::ST_NEXT : sawtc_pkg::ST_FRD;
            end
            sawtc_pkg::ST_NEXT: begin
                n_state = i_stat.cross_pending ? sawtc_pkg::ST_LOOK : sawtc_pkg::ST_DONE;
            end
            sawtc_pkg::ST_DONE: n_state = sawtc_pkg::ST_IDLE;
            default: n_state = sawtc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            sawtc_pkg::ST_CLEAR: o_cmd.clear = 1'b1;
            sawtc_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            sawtc_pkg::ST_CMP:  o_cmd.cmp       = 1'b1;
            sawtc_pkg::ST_RCAP: o_cmd.rd_cap    = 1'b1;
            sawtc_pkg::ST_WR:   o_cmd.wr        = 1'b1;
            sawtc_pkg::ST_VICT: o_cmd.vict      = 1'b1;
            sawtc_pkg::ST_FRD:  o_cmd.fill_rd   = 1'b1;
            sawtc_pkg::ST_FWR:  o_cmd.fill_wr   = 1'b1;
            sawtc_pkg::ST_NEXT: o_cmd.next_part = 1'b1;
            sawtc_pkg::ST_DONE: o_cmd.done      = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

[hdl/sawtc_dp.sv]
// Datapath: backing memory, tag and line stores, access registers and result registers.
module sawtc_dp #(
    parameter int ADDR_BITS = sawtc_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sawtc_pkg::t_cmd      i_cmd,
    output sawtc_pkg::t_stat     o_stat,
    input  logic                 i_mode,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [2:0]           i_length,
    input  logic [31:0]          i_write_data,
    output logic                 o_done,
    output logic [31:0]          o_read_data,
    output logic                 o_first_hit,
    output logic                 o_crosses_line,
    output logic                 o_second_hit
);

    localparam int TAG_W  = ADDR_BITS - sawtc_pkg::TAG_LO;
    localparam int OFF_W  = sawtc_pkg::OFF_BITS;
    localparam int WAY_W  = sawtc_pkg::WAY_BITS;
    localparam int SET_W  = sawtc_pkg::SET_BITS;
    localparam int LIDX_W = sawtc_pkg::LINE_IDX_BITS;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    logic [7:0]       bmem [MEM_DEPTH];
    logic [TAG_W:0]   tmem [sawtc_pkg::TOTAL_LINES];
    logic [7:0]       lmem [1 << LIDX_W];

    logic [ADDR_BITS-1:0] r_clr;
    logic                 r_mode;
    logic [31:0]          r_data;
    logic                 r_part;
    logic [ADDR_BITS-1:0] r_pa;
    logic [2:0]           r_pn;
    logic [2:0]           r_len2;
    logic [1:0]           r_k;
    logic [1:0]           r_bpos;
    logic [WAY_W-1:0]     r_way;
    logic                 r_hit;
    logic [WAY_W-1:0]     r_hway;
    logic                 r_inv_found;
    logic [WAY_W-1:0]     r_inv_way;
    logic [WAY_W-1:0]     r_fway;
    logic [OFF_W-1:0]     r_fk;
    logic [31:0]          r_rd;
    logic                 r_h1;
    logic                 r_h2;
    logic [15:0]          r_lfsr;
    logic [TAG_W:0]       r_tq;
    logic [7:0]           r_mq;
    logic [7:0]           r_lq;

    logic [2:0]       len_n;
    logic [6:0]       off_sum;
    logic [6:0]       room;
    logic             in_cross;
    logic [2:0]       len1;
    logic [SET_W-1:0] set;
    logic [OFF_W-1:0] off;
    logic [TAG_W-1:0] tag;
    logic [OFF_W-1:0] off_k;
    logic [ADDR_BITS-1:0] byte_addr;
    logic [ADDR_BITS-1:0] fill_addr;
    logic             tag_match;
    logic [15:0]      lfsr_n;
    logic [WAY_W-1:0] vict_way;
    logic [7:0]       wr_byte;

    logic                 bm_we;
    logic [ADDR_BITS-1:0] bm_wa;
    logic [7:0]           bm_wd;
    logic [ADDR_BITS-1:0] bm_ra;
    logic                 tm_we;
    logic [sawtc_pkg::SLOT_BITS-1:0] tm_wa;
    logic [TAG_W:0]       tm_wd;
    logic                 lm_we;
    logic [LIDX_W-1:0]    lm_wa;
    logic [7:0]           lm_wd;

    assign len_n    = (i_length == 3'd0) ? 3'd1 :
                      (i_length > 3'(sawtc_pkg::MAX_LEN)) ? 3'(sawtc_pkg::MAX_LEN) : i_length;
    assign off_sum  = {1'b0, i_address[OFF_W-1:0]} + {4'b0, len_n};
    assign room     = 7'(sawtc_pkg::LINE_BYTES) - {1'b0, i_address[OFF_W-1:0]};
    assign in_cross = off_sum > 7'(sawtc_pkg::LINE_BYTES);
    assign len1     = in_cross ? room[2:0] : len_n;

    assign set       = r_pa[sawtc_pkg::TAG_LO-1:OFF_W];
    assign off       = r_pa[OFF_W-1:0];
    assign tag       = r_pa[ADDR_BITS-1:sawtc_pkg::TAG_LO];
    assign off_k     = off + OFF_W'(r_k);
    assign byte_addr = r_pa + ADDR_BITS'(r_k);
    assign fill_addr = {r_pa[ADDR_BITS-1:OFF_W], r_fk};
    assign tag_match = r_tq[TAG_W] && (r_tq[TAG_W-1:0] == tag);
    assign lfsr_n    = (r_lfsr >> 1) ^ (r_lfsr[0] ? sawtc_pkg::LFSR_TAPS : 16'h0000);
    assign vict_way  = r_inv_found ? r_inv_way : lfsr_n[WAY_W-1:0];
    assign wr_byte   = r_data[8*r_bpos +: 8];

    always_comb begin
        bm_we = i_cmd.clear || i_cmd.wr;
        bm_wa = i_cmd.clear ? r_clr : byte_addr;
        bm_wd = i_cmd.clear ? 8'h00 : wr_byte;
        bm_ra = i_cmd.fill_rd ? fill_addr : byte_addr;
        tm_we = i_cmd.clear || i_cmd.vict;
        tm_wa = i_cmd.clear ? r_clr[sawtc_pkg::SLOT_BITS-1:0] : {set, vict_way};
        tm_wd = i_cmd.clear ? '0 : {1'b1, tag};
        lm_we = i_cmd.fill_wr || (i_cmd.wr && r_hit);
        lm_wa = i_cmd.fill_wr ? {set, r_fway, r_fk} : {set, r_hway, off_k};
        lm_wd = i_cmd.fill_wr ? r_mq : wr_byte;
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) bmem[bm_wa] <= bm_wd;
        r_mq <= bmem[bm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tm_we) tmem[tm_wa] <= tm_wd;
        r_tq <= tmem[{set, r_way}];
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) lmem[lm_wa] <= lm_wd;
        r_lq <= lmem[{set, r_hway, off_k}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_lfsr <= sawtc_pkg::LFSR_SEED;
            o_done <= 1'b0;
        end else begin
            o_done <= i_cmd.done;
            if (i_cmd.clear) r_clr <= r_clr + 1'b1;
            if (i_cmd.vict && !r_inv_found) r_lfsr <= lfsr_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode      <= i_mode;
            r_data      <= i_write_data;
            r_pa        <= i_address;
            r_pn        <= len1;
            r_len2      <= len_n - len1;
            r_part      <= 1'b0;
            r_bpos      <= '0;
            r_rd        <= '0;
            r_k         <= '0;
            r_way       <= '0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
        end
        if (i_cmd.cmp) begin
            r_way <= r_way + 1'b1;
            if (tag_match) begin
                r_hit  <= 1'b1;
                r_hway <= r_way;
            end else if (!r_tq[TAG_W] && !r_inv_found) begin
                r_inv_found <= 1'b1;
                r_inv_way   <= r_way;
            end
        end
        if (i_cmd.rd_cap) begin
            r_rd[8*r_bpos +: 8] <= r_hit ? r_lq : r_mq;
        end
        if (i_cmd.rd_cap || i_cmd.wr) begin
            r_k    <= r_k + 1'b1;
            r_bpos <= r_bpos + 1'b1;
        end
        if (i_cmd.vict) begin
            r_fway <= vict_way;
            r_fk   <= '0;
        end
        if (i_cmd.fill_wr) r_fk <= r_fk + 1'b1;
        if (i_cmd.next_part) begin
            if (!r_part) begin
                r_h1 <= r_hit;
                r_h2 <= 1'b0;
            end else begin
                r_h2 <= r_hit;
            end
            r_part      <= 1'b1;
            r_pa        <= {r_pa[ADDR_BITS-1:OFF_W] + 1'b1, OFF_W'(0)};
            r_pn        <= r_len2;
            r_k         <= '0;
            r_way       <= '0;
            r_hit       <= 1'b0;
            r_inv_found <= 1'b0;
        end
        if (i_cmd.done) begin
            o_read_data    <= r_rd;
            o_first_hit    <= r_h1;
            o_crosses_line <= (r_len2 != 3'd0);
            o_second_hit   <= (r_len2 != 3'd0) && r_h2;
        end
    end

    assign o_stat.clr_last      = &r_clr;
    assign o_stat.hit_now       = tag_match;
    assign o_stat.last_way      = (r_way == WAY_W'(sawtc_pkg::NUM_WAYS - 1));
    assign o_stat.last_byte     = ({1'b0, r_k} == r_pn - 3'd1);
    assign o_stat.is_write      = (r_mode == sawtc_pkg::MODE_WRITE);
    assign o_stat.need_fill     = (r_mode != sawtc_pkg::MODE_WRITE) && !r_hit;
    assign o_stat.cross_pending = !r_part && (r_len2 != 3'd0);
    assign o_stat.fill_last     = &r_fk;

endmodule

[hdl/set_assoc_write_through_cache.sv]
// Top level of the eight-way write-through cache with its internal backing memory.
// After reset the block clears its backing memory and tag store, one byte per cycle,
// over every address with busy high. An access then takes, per line touched: a
// probe of each way until a hit or the last way, a read and a capture per byte read
// or one step per byte written, for a read miss a line fill (one victim step, then
// per byte of the line a registered memory read, then a line store write), and a
// step to close the line; a last step ends the access. The result is registered
// on the o_ ports; o_done is high for one cycle and cannot be held.
module set_assoc_write_through_cache #(
    parameter int ADDR_BITS = sawtc_pkg::ADDR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [2:0]           i_length,
    input  logic [31:0]          i_write_data,
    output logic                 o_done,
    output logic [31:0]          o_read_data,
    output logic                 o_first_hit,
    output logic                 o_crosses_line,
    output logic                 o_second_hit
);

    sawtc_pkg::t_cmd  cmd;
    sawtc_pkg::t_stat stat;

    sawtc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    sawtc_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_length       (i_length),
        .i_write_data   (i_write_data),
        .o_done         (o_done),
        .o_read_data    (o_read_data),
        .o_first_hit    (o_first_hit),
        .o_crosses_line (o_crosses_line),
        .o_second_hit   (o_second_hit)
    );

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_second_needs_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_second_hit) |-> o_crosses_line)
        else $error("second hit without line crossing");

endmodule
